@@ sv/fwtr_pkg.sv @@
package fwtr_pkg;

	// limits of the walk
	localparam int MAX_DIM = 1024;
	localparam int MAX_SEG = 64;

	// field widths
	localparam int DIM_W = 11;
	localparam int CRD_W = 10;
	localparam int SEG_W = 7;
	localparam int COL_W = 24;
	localparam int CFG_W = 24;
	localparam int IDX_W = 3;

	// pen position, signed, wide enough for one segment past either edge
	localparam int POS_W = $clog2(MAX_DIM + MAX_SEG) + 2;

	// command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// result status codes
	localparam logic STATUS_PIXEL = 1'b0;
	localparam logic STATUS_STOP  = 1'b1;

	typedef logic signed [POS_W-1:0] pos_t;

	typedef enum logic [1:0] {
		HEAD_UP    = 2'd0,
		HEAD_RIGHT = 2'd1,
		HEAD_DOWN  = 2'd2,
		HEAD_LEFT  = 2'd3
	} heading_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_IMG_WIDTH  = 3'd0,
		CFG_IMG_HEIGHT = 3'd1,
		CFG_START_ROW  = 3'd2,
		CFG_START_COL  = 3'd3,
		CFG_SEG_LEN    = 3'd4,
		CFG_DRAW_COLOR = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic symbol;
		logic restart;
	} in_t;

	typedef struct packed {
		logic [CRD_W-1:0] pixel_row;
		logic [CRD_W-1:0] pixel_col;
		logic [COL_W-1:0] pixel_color;
		logic             status;
		logic             last;
	} out_t;

	// clamped configuration seen by the front
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [CRD_W-1:0] start_row;
		logic [CRD_W-1:0] start_col;
		logic [SEG_W-1:0] seg_len;
	} cfg_eff_t;

	// one segment (or a stop) handed from front to back
	typedef struct packed {
		pos_t     row;
		pos_t     col;
		heading_t head;
		logic     stop;
	} cmd_t;

	// queue handshake towards the back
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

@@ sv/fibonacci_word_turtle_raster.sv @@
// Fibonacci word fractal raster walker. Each input beat carries one digit of
// the word; the block moves a pen one segment of seg_len pixels and gives one
// pixel-write beat per pixel (last marks the final one), or a single stop beat
// once a segment would leave the image; a restart bit reloads the start point.
// The front takes one digit per cycle into a four-entry command queue while it
// is not full; the back end paints one pixel per cycle while the receiver is
// ready, so a digit gives seg_len beats (one for a stop), eight at the default
// length. With the queue empty and the output free, a digit's first pixel beat
// goes through the queue, then the output register. Configuration writes take
// effect at once and must only be made while no digit is in flight.
module fibonacci_word_turtle_raster (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  fwtr_pkg::cfg_idx_t           cfg_index,
	input  logic [fwtr_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  fwtr_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output fwtr_pkg::out_t               out_data
);
	import fwtr_pkg::*;

	logic [DIM_W-1:0] img_width_q;
	logic [DIM_W-1:0] img_height_q;
	logic [CRD_W-1:0] start_row_q;
	logic [CRD_W-1:0] start_col_q;
	logic [SEG_W-1:0] seg_len_q;
	logic [COL_W-1:0] draw_color_q;

	cfg_eff_t cfg_eff;
	logic     q_full;
	logic     push;
	cmd_t     push_cmd;
	logic     pop;
	q_head_t  q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= DIM_W'(MAX_DIM);
			img_height_q <= DIM_W'(MAX_DIM);
			start_row_q  <= '0;
			start_col_q  <= '0;
			seg_len_q    <= SEG_W'(8);
			draw_color_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMG_WIDTH:  img_width_q  <= cfg_wdata[DIM_W-1:0];
				CFG_IMG_HEIGHT: img_height_q <= cfg_wdata[DIM_W-1:0];
				CFG_START_ROW:  start_row_q  <= cfg_wdata[CRD_W-1:0];
				CFG_START_COL:  start_col_q  <= cfg_wdata[CRD_W-1:0];
				CFG_SEG_LEN:    seg_len_q    <= cfg_wdata[SEG_W-1:0];
				CFG_DRAW_COLOR: draw_color_q <= cfg_wdata[COL_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp image size and segment length
	always_comb begin
		cfg_eff.width     = (img_width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : img_width_q;
		cfg_eff.height    = (img_height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : img_height_q;
		cfg_eff.start_row = start_row_q;
		cfg_eff.start_col = start_col_q;
		if (seg_len_q == '0) begin
			cfg_eff.seg_len = SEG_W'(1);
		end else if (seg_len_q > SEG_W'(MAX_SEG)) begin
			cfg_eff.seg_len = SEG_W'(MAX_SEG);
		end else begin
			cfg_eff.seg_len = seg_len_q;
		end
	end

	fwtr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_eff),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	fwtr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (q_head)
	);

	fwtr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg_len    (cfg_eff.seg_len),
		.draw_color (draw_color_q),
		.head       (q_head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

@@ sv/fwtr_queue.sv @@
module fwtr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fwtr_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output fwtr_pkg::q_head_t head
);
	import fwtr_pkg::*;

	cmd_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// status towards both sides
	assign full       = (count_q == QCNT_W'(Q_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/fwtr_front.sv @@
module fwtr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  fwtr_pkg::cfg_eff_t cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  fwtr_pkg::in_t      in_data,
	input  logic               q_full,
	output logic               push,
	output fwtr_pkg::cmd_t     push_cmd
);
	import fwtr_pkg::*;

	pos_t     pen_row_q;
	pos_t     pen_col_q;
	heading_t heading_q;
	logic     index_odd_q;
	logic     stopped_q;

	pos_t     base_row;
	pos_t     base_col;
	heading_t base_head;
	logic     base_odd;
	logic     base_stop;
	pos_t     len_s;
	pos_t     len_m1;
	pos_t     end_row;
	pos_t     end_col;
	pos_t     next_row;
	pos_t     next_col;
	pos_t     h_s;
	pos_t     w_s;
	logic     outside;
	logic     stop_n;
	heading_t turn_head;

	function automatic pos_t restart_pos(input logic rs, input logic [CRD_W-1:0] st,
			input pos_t pen);
		pos_t st_s;
		st_s = pos_t'({{(POS_W-CRD_W){1'b0}}, st});
		return rs ? st_s : pen;
	endfunction

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// restart overrides the walk state for this beat
	always_comb begin
		base_row  = restart_pos(in_data.restart, cfg.start_row, pen_row_q);
		base_col  = restart_pos(in_data.restart, cfg.start_col, pen_col_q);
		base_head = in_data.restart ? HEAD_UP : heading_q;
		base_odd  = in_data.restart ? 1'b0 : index_odd_q;
		base_stop = in_data.restart ? 1'b0 : stopped_q;
	end

	// segment end, next pen and bounds over the whole segment
	always_comb begin
		len_s  = pos_t'({{(POS_W-SEG_W){1'b0}}, cfg.seg_len});
		len_m1 = len_s - pos_t'(1);
		h_s    = pos_t'({{(POS_W-DIM_W){1'b0}}, cfg.height});
		w_s    = pos_t'({{(POS_W-DIM_W){1'b0}}, cfg.width});
		end_row  = base_row;
		end_col  = base_col;
		next_row = base_row;
		next_col = base_col;
		case (base_head)
			HEAD_UP: begin
				end_row  = base_row + len_m1;
				next_row = base_row + len_s;
			end
			HEAD_DOWN: begin
				end_row  = base_row - len_m1;
				next_row = base_row - len_s;
			end
			HEAD_RIGHT: begin
				end_col  = base_col + len_m1;
				next_col = base_col + len_s;
			end
			HEAD_LEFT: begin
				end_col  = base_col - len_m1;
				next_col = base_col - len_s;
			end
			default: begin
				end_row = base_row;
			end
		endcase
		outside = (base_row < 0) || (base_row >= h_s) || (end_row < 0) || (end_row >= h_s)
			|| (base_col < 0) || (base_col >= w_s) || (end_col < 0) || (end_col >= w_s);
		stop_n = base_stop || outside;
		// a zero digit turns left at odd index, right at even index
		if (in_data.symbol) begin
			turn_head = base_head;
		end else if (base_odd) begin
			turn_head = heading_t'(base_head - 2'd1);
		end else begin
			turn_head = heading_t'(base_head + 2'd1);
		end
	end

	// command for the back end
	always_comb begin
		push_cmd.row  = base_row;
		push_cmd.col  = base_col;
		push_cmd.head = base_head;
		push_cmd.stop = stop_n;
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_row_q   <= '0;
			pen_col_q   <= '0;
			heading_q   <= HEAD_UP;
			index_odd_q <= 1'b0;
			stopped_q   <= 1'b0;
		end else if (push) begin
			if (stop_n) begin
				pen_row_q   <= base_row;
				pen_col_q   <= base_col;
				heading_q   <= base_head;
				index_odd_q <= base_odd;
				stopped_q   <= 1'b1;
			end else begin
				pen_row_q   <= next_row;
				pen_col_q   <= next_col;
				heading_q   <= turn_head;
				index_odd_q <= !base_odd;
				stopped_q   <= 1'b0;
			end
		end
	end

endmodule

@@ sv/fwtr_back.sv @@
module fwtr_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [fwtr_pkg::SEG_W-1:0]       seg_len,
	input  logic [fwtr_pkg::COL_W-1:0]       draw_color,
	input  fwtr_pkg::q_head_t                head,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output fwtr_pkg::out_t                   out_data
);
	import fwtr_pkg::*;

	logic             busy_q;
	pos_t             cur_row_q;
	pos_t             cur_col_q;
	heading_t         cur_head_q;
	logic [SEG_W-1:0] cnt_q;
	logic             out_valid_q;
	out_t             out_q;

	logic             advance;
	logic             emit;
	logic             is_stop;
	pos_t             src_row;
	pos_t             src_col;
	heading_t         src_head;
	logic [SEG_W-1:0] src_cnt;
	pos_t             step_row;
	pos_t             step_col;
	out_t             beat;

	// pick the running segment or the queue head
	always_comb begin
		advance  = !out_valid_q || out_ready;
		emit     = advance && (busy_q || head.valid);
		pop      = emit && !busy_q;
		is_stop  = !busy_q && head.cmd.stop;
		src_row  = busy_q ? cur_row_q : head.cmd.row;
		src_col  = busy_q ? cur_col_q : head.cmd.col;
		src_head = busy_q ? cur_head_q : head.cmd.head;
		src_cnt  = busy_q ? cnt_q : seg_len;
	end

	// one pixel step along the heading
	always_comb begin
		step_row = src_row;
		step_col = src_col;
		case (src_head)
			HEAD_UP:    step_row = src_row + pos_t'(1);
			HEAD_DOWN:  step_row = src_row - pos_t'(1);
			HEAD_RIGHT: step_col = src_col + pos_t'(1);
			HEAD_LEFT:  step_col = src_col - pos_t'(1);
			default:    step_row = src_row;
		endcase
	end

	// beat to present
	always_comb begin
		if (is_stop) begin
			beat.pixel_row   = '0;
			beat.pixel_col   = '0;
			beat.pixel_color = '0;
			beat.status      = STATUS_STOP;
			beat.last        = 1'b1;
		end else begin
			beat.pixel_row   = src_row[CRD_W-1:0];
			beat.pixel_col   = src_col[CRD_W-1:0];
			beat.pixel_color = draw_color;
			beat.status      = STATUS_PIXEL;
			beat.last        = (src_cnt == SEG_W'(1));
		end
	end

	// segment walker control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				busy_q <= !is_stop && (src_cnt != SEG_W'(1));
			end
		end
	end

	// walker position and output register
	always_ff @(posedge clk) begin
		if (emit) begin
			cur_row_q  <= step_row;
			cur_col_q  <= step_col;
			cur_head_q <= src_head;
			cnt_q      <= src_cnt - 1'b1;
			out_q      <= beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ sv/fwtr_checker.sv @@
module fwtr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input fwtr_pkg::out_t out_data
);
	import fwtr_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// a stop beat always closes its digit
	a_stop_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STATUS_STOP |-> out_data.last)
		else $error("stop beat without last");

	// a stop beat carries no pixel
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STATUS_STOP |->
		out_data.pixel_row == '0 && out_data.pixel_col == '0 && out_data.pixel_color == '0)
		else $error("stop beat with non-zero fields");

	// a segment streams without gaps once started
	a_seg_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.status == STATUS_PIXEL && !out_data.last |=>
		out_valid && out_data.status == STATUS_PIXEL)
		else $error("segment broken before its last pixel");

endmodule

bind fibonacci_word_turtle_raster fwtr_checker u_fwtr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ tb/testbench.sv @@
module testbench;
	import fwtr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_DIGITS = 170;
	// golden ratio in unsigned fixed point with 32 fraction bits
	localparam longint unsigned PHI_Q32 = 64'd6949403065;

	typedef enum logic {ROW_REG, ROW_DIGIT} row_kind_t;
	typedef enum logic [1:0] {CHECK_MODEL, CHECK_STOP, CHECK_PIXEL} check_t;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_STALLS} rx_mode_t;

	typedef struct packed {
		row_kind_t        kind;
		cfg_idx_t         idx;
		logic [CFG_W-1:0] value;	// register value, or colour of a typed pixel
		in_t              digit;
		check_t           check;
		logic [CRD_W-1:0] row;
		logic [CRD_W-1:0] col;
	} script_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	cfg_idx_t         cfg_index = CFG_IMG_WIDTH;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;

	// shadow registers, loaded as they are written
	logic [DIM_W-1:0] area_w = 11'd1024;
	logic [DIM_W-1:0] area_h = 11'd1024;
	logic [CRD_W-1:0] home_row = '0;
	logic [CRD_W-1:0] home_col = '0;
	logic [SEG_W-1:0] stroke_len = 7'd8;
	logic [COL_W-1:0] ink = 24'hFFFFFF;

	// shadow walk state
	int       row_at = 0;
	int       col_at = 0;
	heading_t facing = HEAD_UP;
	bit       odd_step = 1'b0;
	bit       halted = 1'b0;

	out_t        stroke[$];
	out_t        pixels_due[$];
	script_row_t script[$];

	int       mismatches = 0;
	int       burst_left = 0;
	int       quiet_cycles = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       stall_left = 0;

	fibonacci_word_turtle_raster dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit on_grid(int v, int lim);
		return v >= 0 && v < lim;
	endfunction

	// digit k of the infinite word: b - a is 1 for a '1' and 2 for a '0'
	function automatic bit fib_digit(int k);
		longint unsigned a, b;
		a = (longint'(k + 1) * PHI_Q32) >> 32;
		b = (longint'(k + 2) * PHI_Q32) >> 32;
		return (b - a) == 1;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r == 1)
			return DIM_W'($urandom_range(1025, 2047));
		else if (r <= 4)
			return DIM_W'($urandom_range(1, 8));
		return DIM_W'($urandom_range(16, 1024));
	endfunction

	// mostly inside the image, now and then anywhere
	function automatic logic [CRD_W-1:0] pick_start(logic [DIM_W-1:0] dim);
		if (dim >= 1 && dim <= MAX_DIM && $urandom_range(0, 4) != 0)
			return CRD_W'($urandom_range(0, dim - 1));
		return CRD_W'($urandom_range(0, 1023));
	endfunction

	function automatic script_row_t reg_row(cfg_idx_t idx, logic [CFG_W-1:0] value);
		script_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.value = value;
		return r;
	endfunction

	function automatic script_row_t dig_row(logic symbol, logic restart, check_t check);
		script_row_t r;
		r = '0;
		r.kind = ROW_DIGIT;
		r.digit.symbol = symbol;
		r.digit.restart = restart;
		r.check = check;
		return r;
	endfunction

	function automatic script_row_t dot_row(logic symbol, logic restart,
			logic [CRD_W-1:0] row, logic [CRD_W-1:0] col, logic [COL_W-1:0] colour);
		script_row_t r;
		r = dig_row(symbol, restart, CHECK_PIXEL);
		r.row = row;
		r.col = col;
		r.value = colour;
		return r;
	endfunction

	// pixel beats one digit gives, and the pen move and turn after it
	task automatic walk_digit(in_t d);
		int lim_w, lim_h, n, dr, dc;
		logic [1:0] turned;
		out_t beat;
		if (d.restart) begin
			row_at = home_row;
			col_at = home_col;
			facing = HEAD_UP;
			odd_step = 1'b0;
			halted = 1'b0;
		end
		if (!halted) begin
			lim_w = (area_w > MAX_DIM) ? MAX_DIM : int'(area_w);
			lim_h = (area_h > MAX_DIM) ? MAX_DIM : int'(area_h);
			n = (stroke_len == 0) ? 1 : ((stroke_len > MAX_SEG) ? MAX_SEG : int'(stroke_len));
			dr = (facing == HEAD_UP) ? 1 : ((facing == HEAD_DOWN) ? -1 : 0);
			dc = (facing == HEAD_RIGHT) ? 1 : ((facing == HEAD_LEFT) ? -1 : 0);
			// whole segment must fit, both ends on both axes
			if (!on_grid(row_at, lim_h) || !on_grid(row_at + dr * (n - 1), lim_h) ||
					!on_grid(col_at, lim_w) || !on_grid(col_at + dc * (n - 1), lim_w))
				halted = 1'b1;
		end
		stroke.delete();
		if (halted) begin
			beat = '0;
			beat.status = STATUS_STOP;
			beat.last = 1'b1;
			stroke.push_back(beat);
		end else begin
			for (int j = 0; j < n; j++) begin
				beat.pixel_row = CRD_W'(row_at + dr * j);
				beat.pixel_col = CRD_W'(col_at + dc * j);
				beat.pixel_color = ink;
				beat.status = STATUS_PIXEL;
				beat.last = (j == n - 1);
				stroke.push_back(beat);
			end
			row_at += dr * n;
			col_at += dc * n;
			// a '0' turns left on odd steps, right on even ones
			if (!d.symbol) begin
				turned = odd_step ? facing + 2'd3 : facing + 2'd1;
				facing = heading_t'(turned);
			end
			odd_step = !odd_step;
		end
	endtask

	task automatic put_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			CFG_IMG_WIDTH:  area_w = value[DIM_W-1:0];
			CFG_IMG_HEIGHT: area_h = value[DIM_W-1:0];
			CFG_START_ROW:  home_row = value[CRD_W-1:0];
			CFG_START_COL:  home_col = value[CRD_W-1:0];
			CFG_SEG_LEN:    stroke_len = value[SEG_W-1:0];
			CFG_DRAW_COLOR: ink = value[COL_W-1:0];
			default: ;
		endcase
	endtask

	// every digit gives a beat, so an empty queue means the block is idle
	task automatic settle();
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic draw_setup();
		logic [DIM_W-1:0] w, h;
		logic [SEG_W-1:0] seg;
		int r;
		w = pick_dim();
		h = pick_dim();
		r = $urandom_range(0, 19);
		// short segments mostly, the odd long or out-of-range one
		if (r == 0)
			seg = 7'd64;
		else if (r == 1)
			seg = SEG_W'($urandom_range(65, 127));
		else if (r == 2)
			seg = '0;
		else if (r <= 5)
			seg = SEG_W'($urandom_range(9, 16));
		else
			seg = SEG_W'($urandom_range(1, 8));
		put_reg(CFG_IMG_WIDTH, CFG_W'(w));
		put_reg(CFG_IMG_HEIGHT, CFG_W'(h));
		put_reg(CFG_START_ROW, CFG_W'(pick_start(h)));
		put_reg(CFG_START_COL, CFG_W'(pick_start(w)));
		put_reg(CFG_SEG_LEN, CFG_W'(seg));
		put_reg(CFG_DRAW_COLOR, CFG_W'($urandom_range(0, 24'hFFFFFF)));
		cfg_we <= 1'b0;
	endtask

	// one input beat, then the sender's burst and gap pattern
	task automatic offer_digit(in_t d, check_t chk, out_t typed);
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		walk_digit(d);
		if (chk == CHECK_MODEL)
			foreach (stroke[k]) pixels_due.push_back(stroke[k]);
		else
			pixels_due.push_back(typed);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 7);
		end else begin
			burst_left--;
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 40)
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// receiver: open, coin-toss, or ready with stall stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_left != 0) begin
					out_ready <= 1'b0;
					stall_left <= stall_left - 1;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 5) == 0)
						stall_left <= $urandom_range(1, 12);
				end
			end
		endcase
	end

	// result beats against the oldest expectation
	always @(posedge clk) begin : score
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t: beat expected none got %p", $time, out_data);
			end else begin
				want = pixels_due.pop_front();
				check_field("pixel_row", want.pixel_row, out_data.pixel_row);
				check_field("pixel_col", want.pixel_col, out_data.pixel_col);
				check_field("pixel_color", want.pixel_color, out_data.pixel_color);
				check_field("status", want.status, out_data.status);
				check_field("last", want.last, out_data.last);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		out_t typed;
		in_t d;
		bit writing;
		int sent, phase_len, done, n;
		writing = 1'b0;
		sent = 0;

		// default registers: up, turn left off the edge, stop stays, restart
		script.push_back(dig_row(1'b1, 1'b0, CHECK_MODEL));
		script.push_back(dig_row(1'b0, 1'b0, CHECK_MODEL));
		script.push_back(dig_row(1'b1, 1'b0, CHECK_STOP));
		script.push_back(dig_row(1'b0, 1'b0, CHECK_STOP));
		script.push_back(dig_row(1'b0, 1'b1, CHECK_MODEL));
		script.push_back(dig_row(1'b1, 1'b0, CHECK_MODEL));
		// one-pixel image, one-pixel segment, black
		script.push_back(reg_row(CFG_IMG_WIDTH, 24'd1));
		script.push_back(reg_row(CFG_IMG_HEIGHT, 24'd1));
		script.push_back(reg_row(CFG_START_ROW, 24'd0));
		script.push_back(reg_row(CFG_START_COL, 24'd0));
		script.push_back(reg_row(CFG_SEG_LEN, 24'd1));
		script.push_back(reg_row(CFG_DRAW_COLOR, 24'h000000));
		script.push_back(dot_row(1'b1, 1'b1, 10'd0, 10'd0, 24'h000000));
		script.push_back(dig_row(1'b0, 1'b0, CHECK_STOP));
		// empty image
		script.push_back(reg_row(CFG_IMG_WIDTH, 24'd0));
		script.push_back(reg_row(CFG_IMG_HEIGHT, 24'd1024));
		script.push_back(dig_row(1'b1, 1'b1, CHECK_STOP));
		// oversized image clamps, zero segment acts as one, far corner
		script.push_back(reg_row(CFG_IMG_WIDTH, 24'd2047));
		script.push_back(reg_row(CFG_IMG_HEIGHT, 24'd2047));
		script.push_back(reg_row(CFG_START_ROW, 24'd1023));
		script.push_back(reg_row(CFG_START_COL, 24'd1023));
		script.push_back(reg_row(CFG_SEG_LEN, 24'd0));
		script.push_back(reg_row(CFG_DRAW_COLOR, 24'h123456));
		script.push_back(dot_row(1'b0, 1'b1, 10'd1023, 10'd1023, 24'h123456));
		script.push_back(dig_row(1'b0, 1'b0, CHECK_STOP));
		// segment clamps to the maximum, walk through all four headings
		script.push_back(reg_row(CFG_IMG_WIDTH, 24'd1024));
		script.push_back(reg_row(CFG_IMG_HEIGHT, 24'd1024));
		script.push_back(reg_row(CFG_START_ROW, 24'd512));
		script.push_back(reg_row(CFG_START_COL, 24'd512));
		script.push_back(reg_row(CFG_SEG_LEN, 24'd127));
		script.push_back(reg_row(CFG_DRAW_COLOR, 24'hFFFFFF));
		script.push_back(dig_row(1'b0, 1'b1, CHECK_MODEL));
		script.push_back(dig_row(1'b1, 1'b0, CHECK_MODEL));
		script.push_back(dig_row(1'b0, 1'b0, CHECK_MODEL));
		script.push_back(dig_row(1'b1, 1'b0, CHECK_MODEL));
		script.push_back(dig_row(1'b0, 1'b0, CHECK_MODEL));
		script.push_back(dig_row(1'b1, 1'b0, CHECK_MODEL));
		// segment end one past the top row stops, ending on it fits
		script.push_back(reg_row(CFG_START_ROW, 24'd961));
		script.push_back(reg_row(CFG_START_COL, 24'd0));
		script.push_back(reg_row(CFG_SEG_LEN, 24'd64));
		script.push_back(dig_row(1'b1, 1'b1, CHECK_STOP));
		script.push_back(reg_row(CFG_START_ROW, 24'd960));
		script.push_back(dig_row(1'b1, 1'b1, CHECK_MODEL));
		script.push_back(dig_row(1'b1, 1'b0, CHECK_STOP));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		foreach (script[i]) begin
			if (script[i].kind == ROW_REG) begin
				if (!writing) begin
					in_valid <= 1'b0;
					settle();
					writing = 1'b1;
				end
				put_reg(script[i].idx, script[i].value);
			end else begin
				if (writing) begin
					cfg_we <= 1'b0;
					writing = 1'b0;
				end
				typed = '0;
				typed.last = 1'b1;
				if (script[i].check == CHECK_STOP) begin
					typed.status = STATUS_STOP;
				end else begin
					typed.status = STATUS_PIXEL;
					typed.pixel_row = script[i].row;
					typed.pixel_col = script[i].col;
					typed.pixel_color = script[i].value[COL_W-1:0];
				end
				offer_digit(script[i].digit, script[i].check, typed);
			end
		end

		// random phases: fresh registers, then mostly well-formed walks
		while (sent < RANDOM_DIGITS) begin
			in_valid <= 1'b0;
			settle();
			draw_setup();
			phase_len = $urandom_range(25, 45);
			done = 0;
			while (done < phase_len) begin
				if ($urandom_range(0, 9) < 7) begin
					// restart, then the word from its first digit
					n = $urandom_range(3, 30);
					for (int k = 0; k < n; k++) begin
						d.symbol = fib_digit(k);
						d.restart = (k == 0);
						offer_digit(d, CHECK_MODEL, '0);
					end
				end else begin
					// loose digits, the odd stray restart
					n = $urandom_range(1, 6);
					for (int k = 0; k < n; k++) begin
						d.symbol = $urandom_range(0, 1);
						d.restart = ($urandom_range(0, 7) == 0);
						offer_digit(d, CHECK_MODEL, '0);
					end
				end
				done += n;
				sent += n;
			end
		end

		in_valid <= 1'b0;
		settle();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
